FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the indexed ordered list; iol_ctrl includes them.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

FILE: rtl/iol_pkg.sv
// Types and codes of the indexed ordered list.
// No dependencies; used by the channel interfaces, iol_ctrl and the top module.
package iol_pkg;

  localparam int ACT_W   = 3;
  localparam int IDX_W   = 5;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam action_t ACT_INSERT  = 3'd0;
  localparam action_t ACT_REMOVE  = 3'd1;
  localparam action_t ACT_SEARCH  = 3'd2;
  localparam action_t ACT_READ    = 3'd3;
  localparam action_t ACT_DEQUEUE = 3'd4;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_REJECT = 2'd1;
  localparam status_t ST_MISS   = 2'd2;

  typedef struct packed {
    action_t                  action;
    logic [IDX_W-1:0]         index;
    logic signed [VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  data;
    logic [POS_W-1:0]         position;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
  } out_item_t;

endpackage

FILE: rtl/iol_if.sv
// Valid/ready channel interfaces for list requests and results.
// Depends on iol_pkg for the payload types.
interface iol_in_if import iol_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface iol_out_if import iol_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/iol_store.sv
// Entry store of the list: one write port, one read port with registered data.
// Depends on nothing but its parameters.
module iol_store #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int DW       = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [CAPACITY];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/iol_ctrl.sv
// Sequencer of the list: walks the store one entry a cycle to shift or scan.
// Depends on iol_pkg and assert_macros.svh; drives iol_store.
`include "assert_macros.svh"

module iol_ctrl import iol_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_item_t         in_item,
  output logic             in_ready,
  output logic             res_valid,
  output out_item_t        res_item,
  input  logic             res_ready,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [VAL_W-1:0] mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  logic [VAL_W-1:0] mem_rdata
);

  localparam int IW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
  localparam logic [IW-1:0] CAP_IW  = IW'(CAPACITY);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_FETCH    = 8'b0000_0010,
    S_LATCH    = 8'b0000_0100,
    S_SHIFT_UP = 8'b0000_1000,
    S_SHIFT_DN = 8'b0001_0000,
    S_PLACE    = 8'b0010_0000,
    S_SCAN     = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  action_t                 act_r, act_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0]           ptr_r, ptr_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    pend_r, pend_nxt;
  logic [VAL_W-1:0]        data_r, data_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  status_t                 status_r, status_nxt;

  logic [IW-1:0] idx_w, cnt_w;
  logic [CW:0]   ptr_p1, ptr_p2, cnt_x;
  logic [CW-1:0] ptr_m1, ptr_m2;

  assign idx_w  = IW'(in_item.index);
  assign cnt_w  = IW'(cnt_r);
  assign cnt_x  = {1'b0, cnt_r};
  assign ptr_p1 = {1'b0, ptr_r} + (CW+1)'(1);
  assign ptr_p2 = {1'b0, ptr_r} + (CW+1)'(2);
  assign ptr_m1 = ptr_r - CW'(1);
  assign ptr_m2 = ptr_r - CW'(2);

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    val_nxt    = val_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    data_nxt   = data_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = AW'(ptr_r);
    mem_wdata  = mem_rdata;
    mem_raddr  = AW'(ptr_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_item.action;
          val_nxt    = in_item.value;
          ptr_nxt    = CW'(in_item.index);
          idx_nxt    = CW'(in_item.index);
          pend_nxt   = 1'b0;
          data_nxt   = '0;
          pos_nxt    = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          unique case (in_item.action)
            ACT_INSERT: begin
              priority if (cnt_w >= CAP_IW || idx_w > cnt_w) begin
                status_nxt = ST_REJECT;
              end else if (idx_w == cnt_w) begin
                state_nxt = S_PLACE;
              end else begin
                ptr_nxt   = cnt_r;
                state_nxt = S_SHIFT_UP;
              end
            end
            ACT_REMOVE: begin
              priority if (idx_w >= cnt_w) begin
                status_nxt = ST_REJECT;
              end else if (idx_w + IW'(1) == cnt_w) begin
                // last entry: nothing to close up
                cnt_nxt = cnt_r - CW'(1);
              end else begin
                state_nxt = S_SHIFT_DN;
              end
            end
            ACT_SEARCH: begin
              if (cnt_r == '0) begin
                status_nxt = ST_MISS;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            ACT_READ: begin
              if (idx_w >= cnt_w) begin
                status_nxt = ST_REJECT;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            ACT_DEQUEUE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_REJECT;
              end else begin
                ptr_nxt   = '0;
                idx_nxt   = '0;
                state_nxt = S_FETCH;
              end
            end
            default: begin
              status_nxt = ST_REJECT;
            end
          endcase
        end
      end

      S_FETCH: begin
        state_nxt = S_LATCH;
      end

      S_LATCH: begin
        data_nxt = mem_rdata;
        priority if (act_r != ACT_DEQUEUE) begin
          state_nxt = S_DONE;
        end else if (cnt_r == CW'(1)) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_SHIFT_DN;
        end
      end

      S_SHIFT_DN: begin
        if (!pend_r) begin
          mem_raddr = AW'(ptr_p1);
          pend_nxt  = 1'b1;
        end else begin
          // move the entry above down into the current slot
          mem_we    = 1'b1;
          mem_waddr = AW'(ptr_r);
          ptr_nxt   = CW'(ptr_p1);
          if (ptr_p2 < cnt_x) begin
            mem_raddr = AW'(ptr_p2);
          end else begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_DONE;
          end
        end
      end

      S_SHIFT_UP: begin
        if (!pend_r) begin
          mem_raddr = AW'(ptr_m1);
          pend_nxt  = 1'b1;
        end else begin
          // move the entry below up into the current slot
          mem_we    = 1'b1;
          mem_waddr = AW'(ptr_r);
          ptr_nxt   = ptr_m1;
          if (ptr_m1 > idx_r) begin
            mem_raddr = AW'(ptr_m2);
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r);
        mem_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        if (!pend_r) begin
          pend_nxt = 1'b1;
        end else begin
          priority if ($signed(mem_rdata) == val_r) begin
            pos_nxt   = POS_W'(ptr_r);
            state_nxt = S_DONE;
          end else if (ptr_p1 < cnt_x) begin
            mem_raddr = AW'(ptr_p1);
            ptr_nxt   = CW'(ptr_p1);
          end else begin
            status_nxt = ST_MISS;
            state_nxt  = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    val_r    <= val_nxt;
    ptr_r    <= ptr_nxt;
    idx_r    <= idx_nxt;
    data_r   <= data_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign res_valid          = (state_r == S_DONE);
  assign res_item.data      = data_r;
  assign res_item.position  = pos_r;
  assign res_item.status    = status_r;
  assign res_item.count     = COUNT_W'(cnt_r);

  `ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > CAP_C, "entry count above capacity")
  `ASSERT_PROP(a_we_state, clk, rst_n, mem_we |-> (state_r == S_SHIFT_UP || state_r == S_SHIFT_DN || state_r == S_PLACE), "store written outside a shift or place step")
  `ASSERT_PROP(a_cnt_done, clk, rst_n, (cnt_r != $past(cnt_r)) |-> (state_r == S_DONE), "entry count changed away from completion")
  `ASSERT_PROP(a_accept_busy, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "sequencer stayed idle after accepting a transaction")

endmodule

FILE: rtl/indexed_ordered_list_top.sv
// Read fetches and latches the entry; search scans from entry 0 to a hit or the last entry;
// remove below the last entry shifts those above down; insert below count shifts up from the tail
// and places; dequeue latches entry 0 and shifts the rest down; rejects, empty searches and
// last-entry removes go straight to the result. One transaction in flight: the next is accepted
// in the cycle after the result enters the output register; a held result stalls it. Synchronous
// active-low reset empties the list, no store sweep. Uses iol_pkg, iol_if, iol_ctrl, iol_store.
module indexed_ordered_list_top import iol_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  iol_in_if.sink           in_if,
  iol_out_if.source        out_if
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic             res_valid, res_ready;
  out_item_t        res_item;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;

  iol_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_item   (in_if.payload),
    .in_ready  (in_if.ready),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  iol_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .DW       (VAL_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // take a new result when the register is empty or being drained
  assign res_ready = !out_valid_r || out_if.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;

endmodule
